[rtl/set_assoc_cache_fifo_top_assert.svh]
// assertion macros for the set associative cache top level
// expects clk and arst_n in the scope of each use
`ifndef SET_ASSOC_CACHE_FIFO_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_FIFO_TOP_ASSERT_SVH

// antecedent holds, consequent holds in the cycle after
`define SACF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// antecedent holds, consequent holds in the same cycle
`define SACF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/sacf_pkg.sv]
// shared types and constants for the set associative cache
// no dependencies
`default_nettype none

package sacf_pkg;

	localparam int CFG_W   = 4;
	localparam int REG_IDX_W = 2;
	localparam int AGE_W   = 4;
	localparam logic [AGE_W-1:0] AGE_MAX = 4'd15;

	localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WAYS_IN_USE = 2'd2;

	localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd4;
	localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd0;
	localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 4'd1;

	typedef enum logic {
		MODE_READ  = 1'b0,
		MODE_WRITE = 1'b1
	} mode_t;

	typedef struct packed {
		logic hit;
		logic evict;
	} lookup_t;

endpackage

`default_nettype wire

[rtl/sacf_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module sacf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/sacf_way_logic.sv]
// tag compare, fifo aging and victim choice over one set row
// depends on sacf_pkg
`default_nettype none

module sacf_way_logic #(
	parameter int MAX_WAYS   = 8,
	parameter int ADDR_WIDTH = 48
) (
	input  wire logic [MAX_WAYS*(1+sacf_pkg::AGE_W+ADDR_WIDTH)-1:0] row,
	input  wire logic                                              row_init,
	input  wire logic [$clog2(MAX_WAYS+1)-1:0]                     nw,
	input  wire logic [ADDR_WIDTH-1:0]                             tag,
	output sacf_pkg::lookup_t                                      lk,
	output logic      [MAX_WAYS*(1+sacf_pkg::AGE_W+ADDR_WIDTH)-1:0] new_row
);

	localparam int AW      = sacf_pkg::AGE_W;
	localparam int ENTRY_W = 1 + AW + ADDR_WIDTH;
	localparam int VW      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	logic [MAX_WAYS-1:0] inuse;
	logic [MAX_WAYS-1:0] vld;
	logic [MAX_WAYS-1:0] match;
	logic [MAX_WAYS-1:0] free;
	logic [MAX_WAYS-1:0] aged;
	logic [AW-1:0]       age     [MAX_WAYS];
	logic [AW-1:0]       new_age [MAX_WAYS];
	logic [ADDR_WIDTH-1:0] way_tag [MAX_WAYS];
	logic [AW-1:0]       oldest;
	logic                seen;
	logic                found;
	logic                full;
	logic [VW-1:0]       victim;

	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			inuse[w]   = (w < int'(nw));
			vld[w]     = row_init & row[w*ENTRY_W + ENTRY_W - 1];
			age[w]     = row[w*ENTRY_W + ADDR_WIDTH +: AW];
			way_tag[w] = row[w*ENTRY_W +: ADDR_WIDTH];
			match[w]   = inuse[w] & vld[w] & (way_tag[w] == tag);
			free[w]    = inuse[w] & ~vld[w];
		end
		full = ~|free;

		// ways in front of the first free way grow older
		seen = 1'b0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			aged[w] = inuse[w] & vld[w] & ~seen;
			if (free[w]) begin
				seen = 1'b1;
			end
			if (aged[w] && (age[w] != sacf_pkg::AGE_MAX)) begin
				new_age[w] = age[w] + 1'b1;
			end else begin
				new_age[w] = age[w];
			end
		end

		oldest = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (inuse[w] && (new_age[w] > oldest)) begin
				oldest = new_age[w];
			end
		end

		victim = '0;
		found  = 1'b0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (!found && inuse[w] && (full ? (new_age[w] == oldest) : free[w])) begin
				victim = VW'(w);
				found  = 1'b1;
			end
		end

		for (int w = 0; w < MAX_WAYS; w++) begin
			if (int'(victim) == w) begin
				new_row[w*ENTRY_W +: ENTRY_W] = {1'b1, {AW{1'b0}}, tag};
			end else begin
				new_row[w*ENTRY_W +: ENTRY_W] = {vld[w], new_age[w], way_tag[w]};
			end
		end

		lk.hit   = |match;
		lk.evict = ~(|match) & full;
	end

endmodule

`default_nettype wire

[rtl/set_assoc_cache_fifo_top.sv]
// set associative cache model with fifo replacement, top level
// depends on sacf_pkg, sacf_ram, sacf_way_logic, set_assoc_cache_fifo_top_assert.svh
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | mode, address
// out     | output    | out_valid / out_stall| hit, mem_read, mem_write, counts
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// an access reads the set row from the ram, then compares and ages it and, on a miss,
// writes it back with the new tag while the result is registered.
// one access is in flight at a time; the next word is taken once the row is done.
// a held result does not block a new accept, but completion waits for a free output.
// reset clears the row valid flags and counters and loads the configuration defaults; no clearing pass.
`default_nettype none
`include "set_assoc_cache_fifo_top_assert.svh"

module set_assoc_cache_fifo_top #(
	parameter int MAX_SETS   = 256,
	parameter int MAX_WAYS   = 8,
	parameter int ADDR_WIDTH = 48
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sacf_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [sacf_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           mode,
	input  wire logic [ADDR_WIDTH-1:0]          address,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                hit,
	output logic                                mem_read,
	output logic                                mem_write,
	output logic [31:0]                         read_count,
	output logic [31:0]                         write_count,
	output logic [31:0]                         hit_count,
	output logic [31:0]                         miss_count
);

	localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int IDX_LIM = $clog2(MAX_SETS + 1) - 1;
	localparam int WAYC_W  = $clog2(MAX_WAYS + 1);
	localparam int ROW_W   = MAX_WAYS * (1 + sacf_pkg::AGE_W + ADDR_WIDTH);

	logic [sacf_pkg::CFG_W-1:0] offset_bits_q;
	logic [sacf_pkg::CFG_W-1:0] index_bits_q;
	logic [sacf_pkg::CFG_W-1:0] ways_in_use_q;

	logic [4:0]            ib;
	logic [WAYC_W-1:0]     nw;
	logic [ADDR_WIDTH-1:0] blk;
	logic [SET_W-1:0]      set_idx;
	logic [ADDR_WIDTH-1:0] tag_in;
	logic                  accept;
	logic                  done;

	logic                  valid_s1;
	logic [SET_W-1:0]      set_s1;
	logic [ADDR_WIDTH-1:0] tag_s1;
	logic                  mode_s1;

	logic [MAX_SETS-1:0]   row_init_q;
	logic [ROW_W-1:0]      rdata;
	logic [ROW_W-1:0]      new_row;
	sacf_pkg::lookup_t     lk;

	logic                  out_valid_q;
	logic                  hit_q;
	logic                  mem_read_q;
	logic                  mem_write_q;
	logic [31:0]           reads_q;
	logic [31:0]           writes_q;
	logic [31:0]           hits_q;
	logic [31:0]           misses_q;

	always_comb begin
		if (int'(index_bits_q) > IDX_LIM) begin
			ib = 5'(IDX_LIM);
		end else begin
			ib = 5'(index_bits_q);
		end
		if (ways_in_use_q == '0) begin
			nw = WAYC_W'(1);
		end else if (int'(ways_in_use_q) > MAX_WAYS) begin
			nw = WAYC_W'(MAX_WAYS);
		end else begin
			nw = WAYC_W'(ways_in_use_q);
		end
		blk     = address >> offset_bits_q;
		set_idx = blk[SET_W-1:0] & ~({SET_W{1'b1}} << ib);
		tag_in  = blk >> ib;
	end

	assign in_stall = valid_s1;
	assign accept   = in_valid & ~in_stall;
	assign done     = valid_s1 & (~out_valid_q | ~out_stall);

	sacf_ram #(
		.WIDTH (ROW_W),
		.DEPTH (MAX_SETS)
	) u_row_ram (
		.clk   (clk),
		.we    (done & ~lk.hit),
		.waddr (set_s1),
		.wdata (new_row),
		.re    (accept),
		.raddr (set_idx),
		.rdata (rdata)
	);

	sacf_way_logic #(
		.MAX_WAYS   (MAX_WAYS),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_way_logic (
		.row      (rdata),
		.row_init (row_init_q[set_s1]),
		.nw       (nw),
		.tag      (tag_s1),
		.lk       (lk),
		.new_row  (new_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= sacf_pkg::OFFSET_BITS_RST;
			index_bits_q  <= sacf_pkg::INDEX_BITS_RST;
			ways_in_use_q <= sacf_pkg::WAYS_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sacf_pkg::REG_OFFSET_BITS: offset_bits_q <= cfg_data;
				sacf_pkg::REG_INDEX_BITS:  index_bits_q  <= cfg_data;
				sacf_pkg::REG_WAYS_IN_USE: ways_in_use_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1  <= set_idx;
			tag_s1  <= tag_in;
			mode_s1 <= mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
		end else if (done && !lk.hit) begin
			row_init_q[set_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			reads_q     <= '0;
			writes_q    <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
				if (lk.hit) begin
					hits_q <= hits_q + 32'd1;
				end else begin
					misses_q <= misses_q + 32'd1;
					reads_q  <= reads_q + 32'd1;
				end
				if (mode_s1 == sacf_pkg::MODE_WRITE) begin
					writes_q <= writes_q + 32'd1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			hit_q       <= lk.hit;
			mem_read_q  <= ~lk.hit;
			mem_write_q <= (mode_s1 == sacf_pkg::MODE_WRITE);
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign mem_read    = mem_read_q;
	assign mem_write   = mem_write_q;
	assign read_count  = reads_q;
	assign write_count = writes_q;
	assign hit_count   = hits_q;
	assign miss_count  = misses_q;

	`SACF_ASSERT_NEXT(a_accept_loads_s1, accept, valid_s1, "accepted word did not reach stage one")
	`SACF_ASSERT_NEXT(a_done_gives_out, done, out_valid_q && !valid_s1, "finished word not presented")
	`SACF_ASSERT_NEXT(a_miss_counts, done && !lk.hit, misses_q == $past(misses_q) + 32'd1, "miss not counted")
	`SACF_ASSERT_SAME(a_evict_needs_row, valid_s1 && lk.evict, row_init_q[set_s1], "eviction from unwritten row")

endmodule

`default_nettype wire
